/* design/keyframe_table_with_playhead_defines.svh */
// Assertion macros used by the keyframe table module.
`ifndef KEYFRAME_TABLE_WITH_PLAYHEAD_DEFINES_SVH
`define KEYFRAME_TABLE_WITH_PLAYHEAD_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define KTP_ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define KTP_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* design/ktp_pkg.sv */
`timescale 1ns / 1ps
package ktp_pkg;
    localparam int TimeW = 24;
    localparam int RotW  = 32;
    localparam int PartW = 4;
    localparam int SlotW = 8;
    localparam int CntW  = 9;
    localparam int OpW   = 3;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 24;

    typedef enum logic [OpW-1:0] {
        OP_TICK = 3'd0, OP_SET_TIME = 3'd1, OP_ADD = 3'd2, OP_DELETE = 3'd3,
        OP_NEXT = 3'd4, OP_PREV = 3'd5, OP_COUNT = 3'd6, OP_GET_NTH = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_END_TIME = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LOOP = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_SPEED = 2'd2;

    localparam logic [TimeW-1:0] RESET_PLAYHEAD = 24'd163840;
    localparam logic [TimeW:0] ONE_SECOND = 25'd65536;
    localparam logic [TimeW-1:0] TIME_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [OpW-1:0]   opcode;
        logic [PartW-1:0] part;
        logic [TimeW-1:0] key_time;
        logic             use_playhead;
        logic             fallback;
        logic [RotW-1:0]  rotation_in;
        logic [SlotW-1:0] slot;
        logic [TimeW-1:0] delta;
    } t_req;

    typedef struct packed {
        logic             found;
        logic [1:0]       status;
        logic [TimeW-1:0] out_time;
        logic [RotW-1:0]  out_rotation;
        logic [PartW-1:0] out_part;
        logic [SlotW-1:0] out_slot;
        logic [CntW-1:0]  part_count;
        logic [TimeW-1:0] playhead;
    } t_rsp;
endpackage

/* design/ktp_req_if.sv */
`timescale 1ns / 1ps
interface ktp_req_if import ktp_pkg::*; ;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/ktp_rsp_if.sv */
`timescale 1ns / 1ps
interface ktp_rsp_if import ktp_pkg::*; ;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/keyframe_table_with_playhead.sv */
`timescale 1ns / 1ps
// Keyframe table with a playhead. Keyframes live in one synchronous memory of
// TABLE_DEPTH entries with a registered read. Set_time and add answer through
// S_DONE, and tick answers through S_MUL and then S_DONE. Next, previous,
// count and get_nth scan the table one entry per cycle, and a next or
// previous with fallback may scan twice. A delete shifts the later entries
// down one per cycle. The tick product goes through one registered
// multiply. One request is worked at a time, and the next request is taken
// only once the response has been accepted.
`include "keyframe_table_with_playhead_defines.svh"
module keyframe_table_with_playhead import ktp_pkg::*; #(
    parameter int TABLE_DEPTH = 256,
    parameter int PART_COUNT = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [CfgDataW-1:0] i_cfg_data,
    ktp_req_if.sink             req,
    ktp_rsp_if.source           rsp
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int KCW = $clog2(TABLE_DEPTH + 1);
    localparam int EW = TimeW + PartW + RotW;

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_SCAN, S_SHIFT, S_DONE
    } t_state;

    // Configuration registers.
    logic [TimeW-1:0] r_end_time;
    logic             r_loop;
    logic [15:0]      r_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_time <= '0;
            r_loop <= 1'b0;
            r_speed <= 16'd256;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_END_TIME: r_end_time <= i_cfg_data;
                CFG_LOOP: r_loop <= i_cfg_data[0];
                CFG_SPEED: r_speed <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Keyframe memory.
    logic [EW-1:0] mem [TABLE_DEPTH];
    logic [EW-1:0] r_rd;
    logic [AW-1:0] mem_ra, mem_wa;
    logic          mem_we;
    logic [EW-1:0] mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rd <= mem[mem_ra];
    end

    t_state r_state;
    t_req   r_req;
    logic [TimeW-1:0] r_ph;
    logic [KCW-1:0]   r_kc;
    logic [KCW-1:0]   r_idx;      // address issued
    logic [KCW-1:0]   r_didx;     // address of the data in r_rd
    logic             r_dv;       // r_rd holds a valid scan entry
    logic             r_pass2;
    logic             r_dir;      // 0 next, 1 previous
    logic [TimeW-1:0] r_t;
    logic             r_hit;
    logic [TimeW-1:0] r_best;
    logic [EW-1:0]    r_hent;
    logic [KCW-1:0]   r_hidx;
    logic [KCW-1:0]   r_cnt;
    logic [39:0]      r_prod;
    logic             r_ovalid;
    t_rsp             r_rsp;

    logic part_ok;
    assign part_ok = {{(9 - PartW){1'b0}}, r_req.part} < 9'(PART_COUNT);

    assign req.ready = (r_state == S_IDLE) && !r_ovalid;
    assign rsp.valid = r_ovalid;
    assign rsp.payload = r_rsp;

    // Fields of the entry in the read register.
    logic [TimeW-1:0] e_time;
    logic [PartW-1:0] e_part;
    assign e_time = r_rd[EW-1 -: TimeW];
    assign e_part = r_rd[RotW +: PartW];

    logic [TimeW:0] bound;
    assign bound = {1'b0, r_end_time} + ONE_SECOND;

    // Checks on the incoming request and its initial response.
    logic add_full;
    logic add_bad_part;
    logic del_bad;
    t_rsp n_rsp;
    always_comb begin
        add_full = {1'b0, r_kc} >= (KCW+1)'(TABLE_DEPTH);
        add_bad_part = !({{(9 - PartW){1'b0}}, req.payload.part} < 9'(PART_COUNT));
        del_bad = (32'(req.payload.slot) >= 32'(r_kc)) ||
                  (32'(req.payload.slot) >= 32'(TABLE_DEPTH));
        n_rsp = '0;
        if (req.payload.opcode == OP_ADD) begin
            if (add_full) n_rsp.status = ST_FULL;
            else if (add_bad_part) n_rsp.status = ST_RANGE;
        end else if (req.payload.opcode == OP_DELETE && del_bad) begin
            n_rsp.status = ST_RANGE;
        end
    end

    // Memory port control.
    always_comb begin
        mem_ra = r_idx[AW-1:0];
        mem_we = 1'b0;
        mem_wa = r_kc[AW-1:0];
        mem_wd = {r_req.key_time, r_req.part, r_req.rotation_in};
        if (r_state == S_IDLE && req.valid && req.ready) begin
            mem_we = (req.payload.opcode == OP_ADD) && !add_full && !add_bad_part;
            mem_wd = {req.payload.key_time, req.payload.part,
                      req.payload.rotation_in};
        end else if (r_state == S_SHIFT && r_dv) begin
            mem_we = 1'b1;
            mem_wa = AW'(r_didx - KCW'(1));
            mem_wd = r_rd;
        end
    end

    logic [KCW-1:0] n_cnt;
    logic           match;
    logic           better;
    always_comb begin
        match = r_dv && (e_part == r_req.part) && part_ok;
        if (!r_dir) begin
            better = ({1'b0, e_time} >= {1'b0, r_t}) &&
                     (r_hit ? (e_time < r_best) : ({1'b0, e_time} < bound));
        end else begin
            better = (e_time <= r_t) && (!r_hit || e_time > r_best);
        end
        n_cnt = r_cnt + (match ? KCW'(1) : KCW'(0));
    end

    logic [TimeW+16:0] sum;
    assign sum = {17'd0, r_ph} + {1'b0, r_prod[39:8]} ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph <= RESET_PLAYHEAD;
            r_kc <= '0;
            r_ovalid <= 1'b0;
            r_dv <= 1'b0;
        end else begin
            if (rsp.valid && rsp.ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (req.valid && req.ready) begin
                        r_req <= req.payload;
                        r_idx <= (req.payload.opcode == OP_DELETE) ?
                                 KCW'(req.payload.slot) + KCW'(1) : '0;
                        r_dv <= 1'b0;
                        r_hit <= 1'b0;
                        r_cnt <= '0;
                        r_pass2 <= 1'b0;
                        r_dir <= (req.payload.opcode == OP_PREV);
                        r_t <= req.payload.use_playhead ? r_ph : req.payload.key_time;
                        r_rsp <= n_rsp;
                        r_prod <= req.payload.delta * r_speed;
                        case (req.payload.opcode)
                            OP_TICK: r_state <= S_MUL;
                            OP_SET_TIME: begin
                                r_ph <= req.payload.key_time;
                                r_state <= S_DONE;
                            end
                            OP_ADD: begin
                                if (!add_full && !add_bad_part) r_kc <= r_kc + KCW'(1);
                                r_state <= S_DONE;
                            end
                            OP_DELETE: r_state <= del_bad ? S_DONE : S_SHIFT;
                            default: r_state <= S_SCAN;
                        endcase
                    end
                end
                S_MUL: begin
                    if (r_ph < r_end_time) begin
                        if (r_loop && (sum > {17'd0, TIME_MAX} ||
                                       sum[TimeW-1:0] >= r_end_time))
                            r_ph <= '0;
                        else if (sum > {17'd0, TIME_MAX}) r_ph <= TIME_MAX;
                        else r_ph <= sum[TimeW-1:0];
                    end else if (r_loop) r_ph <= '0;
                    r_state <= S_DONE;
                end
                S_SHIFT: begin
                    // Read entry i, write it to i-1 next cycle.
                    r_dv <= r_idx < r_kc;
                    r_didx <= r_idx;
                    r_idx <= r_idx + KCW'(1);
                    if (!(r_idx < r_kc) && !r_dv) begin
                        r_kc <= r_kc - KCW'(1);
                        r_state <= S_DONE;
                    end
                end
                S_SCAN: begin
                    r_dv <= r_idx < r_kc;
                    r_didx <= r_idx;
                    if (r_idx < r_kc) r_idx <= r_idx + KCW'(1);
                    if (match) begin
                        r_cnt <= n_cnt;
                        if (r_req.opcode == OP_GET_NTH) begin
                            if (!r_hit &&
                                (KCW+SlotW)'(r_cnt) == (KCW+SlotW)'(r_req.slot)) begin
                                r_hit <= 1'b1;
                                r_hent <= r_rd;
                                r_hidx <= r_didx;
                            end
                        end else if (better) begin
                            r_hit <= 1'b1;
                            r_best <= e_time;
                            r_hent <= r_rd;
                            r_hidx <= r_didx;
                        end
                    end
                    if (!(r_idx < r_kc) && !r_dv) begin
                        if ((r_req.opcode == OP_NEXT || r_req.opcode == OP_PREV) &&
                            !r_hit && r_req.fallback && !r_pass2) begin
                            r_pass2 <= 1'b1;
                            r_dir <= !r_dir;
                            r_t <= r_ph;
                            r_idx <= '0;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    r_rsp.playhead <= r_ph;
                    if (r_req.opcode == OP_COUNT || r_req.opcode == OP_GET_NTH)
                        r_rsp.part_count <= CntW'(r_cnt);
                    if (r_req.opcode == OP_GET_NTH && !r_hit)
                        r_rsp.status <= ST_RANGE;
                    if (r_hit && r_req.opcode != OP_COUNT &&
                        r_req.opcode != OP_DELETE) begin
                        r_rsp.found <= 1'b1;
                        r_rsp.out_time <= r_hent[EW-1 -: TimeW];
                        r_rsp.out_part <= r_hent[RotW +: PartW];
                        r_rsp.out_rotation <= r_hent[RotW-1:0];
                        r_rsp.out_slot <= SlotW'(r_hidx);
                    end
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Checks.
    `KTP_ASSERT_IMPL(a_kc_bound, i_clk, i_rst_n, 1'b1, {1'b0, r_kc} <= (KCW+1)'(TABLE_DEPTH), "key count overflow")
    `KTP_ASSERT_IMPL(a_no_req_busy, i_clk, i_rst_n, r_state != S_IDLE, !req.ready, "ready while busy")
    `KTP_ASSERT_NEXT(a_done_valid, i_clk, i_rst_n, r_state == S_DONE, rsp.valid, "response lost")
endmodule
